### rtl/core/assert_macros.svh
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define FRS_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");

// condition must never be seen outside reset
`define FRS_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");

`endif

### rtl/core/frs_pkg.sv
package frs_pkg;

	// region geometry
	localparam logic [31:0] REGION_START = 32'd134234112;
	localparam int unsigned REGION_BYTES = 32768;
	localparam int unsigned PAGE_BYTES = 2048;

	// halfword store geometry
	localparam int unsigned STORE_DEPTH = (REGION_BYTES + 1) / 2;
	localparam int unsigned IDX_W = $clog2(STORE_DEPTH);
	localparam int unsigned PAGE_HW = PAGE_BYTES / 2;
	localparam logic [31:0] PAGE_MASK = 32'(PAGE_BYTES - 1);

	// largest start offset that still fits the access
	localparam logic [31:0] LIM_PAGE = 32'(REGION_BYTES - PAGE_BYTES);
	localparam logic [31:0] LIM_HALF = 32'(REGION_BYTES - 2);

	localparam logic [15:0] ERASED_HW = 16'hFFFF;

	// request kinds
	localparam logic [1:0] KIND_ERASE = 2'd0;
	localparam logic [1:0] KIND_WRITE = 2'd1;
	localparam logic [1:0] KIND_READ = 2'd2;
	localparam logic [1:0] KIND_SPARE = 2'd3;

	// response status codes
	localparam logic [1:0] STAT_OK = 2'd0;
	localparam logic [1:0] STAT_ALIGN = 2'd1;
	localparam logic [1:0] STAT_RANGE = 2'd2;

	// memory port request
	typedef struct packed {
		logic en;
		logic we;
		logic [IDX_W-1:0] addr;
		logic [15:0] wdata;
	} frs_mem_req_t;

endpackage

### rtl/core/frs_req_if.sv
interface frs_req_if;
	logic valid;
	logic ready;
	logic [1:0] kind;
	logic [31:0] address;
	logic [15:0] write_value;

	modport source (output valid, kind, address, write_value, input ready);
	modport sink (input valid, kind, address, write_value, output ready);
endinterface

### rtl/core/frs_rsp_if.sv
interface frs_rsp_if;
	logic valid;
	logic ready;
	logic [1:0] status;
	logic [15:0] read_value;

	modport source (output valid, status, read_value, input ready);
	modport sink (input valid, status, read_value, output ready);
endinterface

### rtl/core/frs_ram.sv
module frs_ram #(
	parameter int unsigned ADDR_W = 14,
	parameter int unsigned DATA_W = 16
) (
	input logic clk,
	input logic en,
	input logic we,
	input logic [ADDR_W-1:0] addr,
	input logic [DATA_W-1:0] wdata,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [2**ADDR_W];
	logic [DATA_W-1:0] rdata_q;

	// single port, registered read, read data holds while idle
	always_ff @(posedge clk) begin
		if (en) begin
			if (we) begin
				mem_q[addr] <= wdata;
			end else begin
				rdata_q <= mem_q[addr];
			end
		end
	end

	assign rdata = rdata_q;

endmodule

### rtl/core/frs_ctrl.sv
`include "assert_macros.svh"

module frs_ctrl (
	input logic clk,
	input logic arst_n,
	frs_req_if.sink req,
	frs_rsp_if.source rsp,
	output frs_pkg::frs_mem_req_t mem,
	input logic [15:0] mem_rdata
);
	import frs_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC,
		S_READ,
		S_ERASE
	} state_t;

	state_t state_q;
	logic [1:0] kind_q;
	logic [31:0] addr_q;
	logic [15:0] val_q;
	logic [IDX_W-1:0] sweep_q;
	logic [IDX_W-1:0] last_q;
	logic out_valid_q;
	logic [1:0] out_status_q;
	logic [15:0] out_rd_q;

	logic load_ok;
	logic rsp_load;
	logic [32:0] off;
	logic in_rng;
	logic misaligned;
	logic [1:0] status;
	logic [IDX_W-1:0] idx;
	logic at_last;

	// output register can take a result this cycle
	assign load_ok = !out_valid_q || rsp.ready;
	assign at_last = (sweep_q == last_q);

	// alignment and non-wrapping range check of the held request
	always_comb begin
		off = {1'b0, addr_q} - {1'b0, REGION_START};
		idx = off[IDX_W:1];
		if (kind_q == KIND_ERASE) begin
			misaligned = (addr_q & PAGE_MASK) != 32'd0;
			in_rng = !off[32] && (off[31:0] <= LIM_PAGE);
		end else begin
			misaligned = addr_q[0];
			in_rng = !off[32] && (off[31:0] <= LIM_HALF);
		end
		if (kind_q == KIND_SPARE) begin
			status = STAT_OK;
		end else if (misaligned) begin
			status = STAT_ALIGN;
		end else if (!in_rng) begin
			status = STAT_RANGE;
		end else begin
			status = STAT_OK;
		end
	end

	// a result enters the output register this cycle
	always_comb begin
		rsp_load = 1'b0;
		case (state_q)
			S_EXEC: begin
				rsp_load = load_ok && !(status == STAT_OK &&
					(kind_q == KIND_READ || kind_q == KIND_ERASE));
			end
			S_READ: begin
				rsp_load = load_ok;
			end
			S_ERASE: begin
				rsp_load = at_last && load_ok;
			end
			default: begin
				rsp_load = 1'b0;
			end
		endcase
	end

	// memory port
	always_comb begin
		mem.en = 1'b0;
		mem.we = 1'b0;
		mem.addr = sweep_q;
		mem.wdata = ERASED_HW;
		case (state_q)
			S_CLEAR: begin
				mem.en = 1'b1;
				mem.we = 1'b1;
			end
			S_EXEC: begin
				if (load_ok && status == STAT_OK) begin
					if (kind_q == KIND_WRITE) begin
						mem.en = 1'b1;
						mem.we = 1'b1;
						mem.addr = idx;
						mem.wdata = val_q;
					end else if (kind_q == KIND_READ) begin
						mem.en = 1'b1;
						mem.addr = idx;
					end
				end
			end
			S_ERASE: begin
				if (!at_last || load_ok) begin
					mem.en = 1'b1;
					mem.we = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			sweep_q <= '0;
			last_q <= '0;
			out_valid_q <= 1'b0;
			out_status_q <= STAT_OK;
			out_rd_q <= '0;
			kind_q <= KIND_ERASE;
			addr_q <= '0;
			val_q <= '0;
		end else begin
			if (rsp_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					sweep_q <= sweep_q + 1'b1;
					if (sweep_q == IDX_W'(STORE_DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						kind_q <= req.kind;
						addr_q <= req.address;
						val_q <= req.write_value;
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (load_ok) begin
						if (status == STAT_OK && kind_q == KIND_READ) begin
							state_q <= S_READ;
						end else if (status == STAT_OK && kind_q == KIND_ERASE) begin
							sweep_q <= idx;
							last_q <= idx + IDX_W'(PAGE_HW - 1);
							state_q <= S_ERASE;
						end else begin
							out_status_q <= status;
							out_rd_q <= '0;
							state_q <= S_IDLE;
						end
					end
				end
				S_READ: begin
					if (load_ok) begin
						out_status_q <= STAT_OK;
						out_rd_q <= mem_rdata;
						state_q <= S_IDLE;
					end
				end
				S_ERASE: begin
					if (!at_last) begin
						sweep_q <= sweep_q + 1'b1;
					end else if (load_ok) begin
						out_status_q <= STAT_OK;
						out_rd_q <= '0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign req.ready = (state_q == S_IDLE);
	assign rsp.valid = out_valid_q;
	assign rsp.status = out_status_q;
	assign rsp.read_value = out_rd_q;

	// an accepted request is checked in the following cycle
	`FRS_ASSERT(a_accept_exec, clk, arst_n, (req.valid && req.ready) |=> (state_q == S_EXEC))
	// no store write while waiting on read data
	`FRS_NEVER(a_no_write_in_read, clk, arst_n, (state_q == S_READ) && mem.en)
	// erase sweep stays inside its page
	`FRS_ASSERT(a_erase_bound, clk, arst_n, (state_q == S_ERASE) |-> ((last_q - sweep_q) <= IDX_W'(PAGE_HW - 1)))
	// a new response only comes out of an active operation
	`FRS_ASSERT(a_rsp_source, clk, arst_n, $rose(out_valid_q) |-> ($past(state_q) == S_EXEC || $past(state_q) == S_READ || $past(state_q) == S_ERASE))

endmodule

### rtl/core/flash_region_erase_program_store.sv
// channel  | dir | payload                       | handshake
// req      | in  | kind, address, write_value    | valid / ready
// rsp      | out | status, read_value            | valid / ready
//
// write, kind 3 and any rejected request: the response is registered from the check state, then back to idle
// read: an extra read state waits on the registered memory read
// page erase: one halfword written per cycle over the page, the last one held while the response register is full
// after reset a clearing pass writes 0xFFFF over all 16384 halfwords
// with req ready low; one request is in flight at a time
// a held response stalls the next result, not the next accept
module flash_region_erase_program_store (
	input logic clk,
	input logic arst_n,
	frs_req_if.sink req,
	frs_rsp_if.source rsp
);
	import frs_pkg::*;

	frs_mem_req_t mem;
	logic [15:0] mem_rdata;

	// request sequencer
	frs_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req(req),
		.rsp(rsp),
		.mem(mem),
		.mem_rdata(mem_rdata)
	);

	// halfword store
	frs_ram #(
		.ADDR_W(IDX_W),
		.DATA_W(16)
	) u_ram (
		.clk(clk),
		.en(mem.en),
		.we(mem.we),
		.addr(mem.addr),
		.wdata(mem.wdata),
		.rdata(mem_rdata)
	);

endmodule
